// ----- design/smp_pkg.sv -----
package smp_pkg;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  localparam int unsigned CntW   = 7;
  localparam int unsigned IvalW  = 14;
  localparam int unsigned LimW   = 13;
  localparam int unsigned ThrW   = 7;
  localparam int unsigned RandW  = 31;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_INTERVAL_LIMIT  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_DECAY_THRESHOLD = 1'b1;

  localparam logic [1:0] KIND_OPEN     = 2'd0;
  localparam logic [1:0] KIND_RESTRICT = 2'd1;

  localparam logic [CntW-1:0]  CountMax = 7'd127;
  localparam logic [IvalW-1:0] IvalMax  = 14'd16383;

  typedef struct packed {
    logic [CntW-1:0]  open_cnt;
    logic [CntW-1:0]  restr_cnt;
    logic             kind;
    logic             valid;
    logic [IvalW-1:0] interval;
    logic [IvalW-1:0] countdown;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [RandW-1:0] dividend;
    logic [IvalW:0]   divisor;
  } div_req_t;

endpackage

// ----- design/smp_mod.sv -----
module smp_mod (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  smp_pkg::div_req_t        req_i,
  output logic                     done_o,
  output logic [smp_pkg::IvalW:0]  rem_o
);

  localparam int unsigned DW = smp_pkg::RandW;
  localparam int unsigned RW = smp_pkg::IvalW + 1;

  logic [DW-1:0] quo_q, quo_d;
  logic [RW:0]   rem_q, rem_d;
  logic [RW-1:0] dvs_q, dvs_d;
  logic [4:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [RW:0]   shifted;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = '0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 5'(DW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // two bits per cycle, one bit in the final step
      shifted = {rem_q[RW-1:0], quo_q[DW-1]};
      if (shifted >= {1'b0, dvs_q}) shifted = shifted - {1'b0, dvs_q};
      quo_d = {quo_q[DW-2:0], 1'b0};
      rem_d = shifted;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        shifted = {rem_d[RW-1:0], quo_d[DW-1]};
        if (shifted >= {1'b0, dvs_q}) shifted = shifted - {1'b0, dvs_q};
        quo_d = {quo_d[DW-2:0], 1'b0};
        rem_d = shifted;
        if (cnt_q == 5'd1) begin
          busy_d = 1'b0;
          done_d = 1'b1;
          cnt_d  = 5'd0;
        end else begin
          cnt_d = cnt_q - 5'd2;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[RW-1:0];

endmodule

// ----- design/size_mapping_predictor_unit.sv -----
// Size-indexed mapping-kind predictor.
// Input stream s_axis: one transfer per record or query operation.
//   tdata = {rand_value, mapping_kind, entry_size}, tuser = opcode.
// Output stream m_axis: one transfer per input, tdata = {valid, kind, fast_hit}.
// Configuration: cfg_we_i with cfg_idx_i (0 interval_limit, 1 decay_threshold).
// Flow: record and fast query pass memory read, update and result;
//   a slow-path query needing a remainder also passes the divider start
//   and the divider, which retires two quotient bits per cycle, one in its last.
// One operation is in flight at a time; s_axis_tready is low while busy.
// Reset: after rst_ni rises the table is cleared, one entry per cycle, for
//   all TABLE_ENTRIES entries; no input is taken during that pass.
// Stall: the result is held in an output register until m_axis_tready; the
//   next input is taken meanwhile and waits at the write-back stage.
module size_mapping_predictor_unit #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // entry_size[31:0], mapping_kind[33:32], rand_value[64:34]
  input  logic        s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // fast_hit[0], predicted_kind[1], entry_valid[2]
  input  logic        cfg_we_i,
  input  logic [smp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [12:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = smp_pkg::CntW;
  localparam int unsigned IW = smp_pkg::IvalW;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_CALC, ST_DIV, ST_OUT
  } state_e;

  state_e state_q;
  logic [AW:0] clr_q;
  logic [smp_pkg::LimW-1:0] lim_q;
  logic [smp_pkg::ThrW-1:0] thr_q;

  smp_pkg::entry_t mem [TABLE_ENTRIES];
  smp_pkg::entry_t rd_q, ent_q;
  logic [AW-1:0] addr_q;
  logic op_q, oor_q;
  logic [1:0] kind_q;
  logic [smp_pkg::RandW-1:0] rnd_q;
  logic [2:0] res_q;
  logic [2:0] pend_q;
  logic ovalid_q;
  logic we;
  logic [AW-1:0] waddr;
  smp_pkg::entry_t wdata;

  smp_pkg::div_req_t dreq;
  logic ddone;
  logic [IW:0] drem;

  // record update
  smp_pkg::entry_t rec_e;
  logic [CW-1:0] o, r;
  logic [10:0] o10, r10;
  logic [CW:0] sum;

  // update stage
  smp_pkg::entry_t calc_e;
  logic [2:0] calc_res;
  logic calc_div;

  always_comb begin
    rec_e = rd_q;
    o = rd_q.open_cnt;
    r = rd_q.restr_cnt;
    if (kind_q == smp_pkg::KIND_OPEN && o < smp_pkg::CountMax) o = o + 1'b1;
    else if (kind_q == smp_pkg::KIND_RESTRICT && r < smp_pkg::CountMax) r = r + 1'b1;
    o10 = {1'b0, o, 3'b0} + {3'b0, o, 1'b0};
    r10 = {1'b0, r, 3'b0} + {3'b0, r, 1'b0};
    if (r == '0) begin
      rec_e.kind = 1'b0; rec_e.valid = 1'b1;
    end else if (o == '0) begin
      rec_e.kind = 1'b1; rec_e.valid = 1'b1;
    end else if (o10 < {4'b0, r}) begin
      rec_e.kind = 1'b1; rec_e.valid = 1'b1;
    end else if ({4'b0, o} <= r10) begin
      rec_e.kind = 1'b0; rec_e.valid = 1'b0;
    end else begin
      rec_e.kind = 1'b0; rec_e.valid = 1'b1;
    end
    sum = {1'b0, o} + {1'b0, r};
    if (sum >= {1'b0, thr_q}) begin
      o = o >> 1;
      r = r >> 1;
    end
    rec_e.open_cnt = o;
    rec_e.restr_cnt = r;
  end

  always_comb begin
    calc_e   = rd_q;
    calc_res = {rd_q.valid, rd_q.kind, 1'b0};
    calc_div = 1'b0;
    if (op_q == smp_pkg::OP_RECORD) begin
      calc_e   = rec_e;
      calc_res = {rec_e.valid, rec_e.kind, 1'b0};
    end else if (rd_q.valid && rd_q.countdown != '0) begin
      calc_e.countdown = rd_q.countdown - 1'b1;
      calc_res = {rd_q.valid, rd_q.kind, 1'b1};
    end else if (!rd_q.valid || rd_q.interval == '0) begin
      calc_e.interval  = IW'(1);
      calc_e.countdown = IW'(1);
    end else begin
      calc_div = 1'b1;
    end
    if (oor_q) calc_res = '0;
  end

  logic [IW+1:0] grown;
  logic [IW+1:0] lim2;

  always_comb begin
    lim2  = {2'b0, lim_q, 1'b0};
    grown = (ent_q.interval < {1'b0, lim_q})
          ? {2'b0, ent_q.interval} + {1'b0, drem}
          : lim2 + {1'b0, drem};
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'b0, res_q};

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[addr_q];
  end

  smp_mod u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .done_o(ddone),
    .rem_o (drem)
  );

  always_comb begin
    we = 1'b0;
    waddr = addr_q;
    wdata = ent_q;
    dreq = '0;
    if (state_q == ST_CLEAR) begin
      we = 1'b1;
      waddr = clr_q[AW-1:0];
      wdata = '0;
    end else if (state_q == ST_OUT && !ovalid_q && !oor_q) begin
      we = 1'b1;
    end
    if (state_q == ST_CALC && calc_div) begin
      dreq.start = 1'b1;
      dreq.dividend = rnd_q;
      dreq.divisor = (rd_q.interval < {1'b0, lim_q})
                   ? {rd_q.interval, 1'b0} : {2'b0, lim_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      lim_q    <= 13'd1024;
      thr_q    <= 7'd64;
      ovalid_q <= 1'b0;
      res_q    <= '0;
      pend_q   <= '0;
      op_q     <= 1'b0;
      kind_q   <= '0;
      rnd_q    <= '0;
      addr_q   <= '0;
      oor_q    <= 1'b0;
      ent_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          smp_pkg::CFG_INTERVAL_LIMIT:  lim_q <= cfg_data_i;
          smp_pkg::CFG_DECAY_THRESHOLD: thr_q <= cfg_data_i[smp_pkg::ThrW-1:0];
          default: ;
        endcase
      end
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AW+1)'(TABLE_ENTRIES - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_q   <= s_axis_tuser;
            kind_q <= s_axis_tdata[33:32];
            rnd_q  <= s_axis_tdata[64:34];
            addr_q <= s_axis_tdata[AW-1:0];
            oor_q  <= (s_axis_tdata[31:0] >= 32'(TABLE_ENTRIES));
            state_q <= ST_READ;
          end
        end
        ST_READ: state_q <= ST_CALC;
        ST_CALC: begin
          ent_q   <= calc_e;
          pend_q  <= calc_res;
          state_q <= calc_div ? ST_DIV : ST_OUT;
        end
        ST_DIV: begin
          if (ddone) begin
            if (ent_q.interval >= {1'b0, lim_q} && lim_q == '0) begin
              ent_q.interval  <= '0;
              ent_q.countdown <= '0;
            end else if (grown > {2'b0, smp_pkg::IvalMax}) begin
              ent_q.interval  <= smp_pkg::IvalMax;
              ent_q.countdown <= smp_pkg::IvalMax;
            end else begin
              ent_q.interval  <= grown[IW-1:0];
              ent_q.countdown <= grown[IW-1:0];
            end
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
            res_q    <= pend_q;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
